// ----- hw/rtl/fcu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fcu_pkg;

  // Single-precision constants used by the series and the final scaling
  localparam logic [31:0] FP_COEF_QUAD = 32'h3F56594B;  // 0.8373
  localparam logic [31:0] FP_COEF_LIN  = 32'h3F5D0000;  // 0.86328125
  localparam logic [31:0] FP_ONE       = 32'h3F800000;
  localparam logic [31:0] FP_HALF      = 32'h3F000000;
  localparam logic [31:0] FP_INF       = 32'h7F800000;

  localparam logic [7:0] SCALE_EXP     = 8'd126;
  localparam logic [7:0] EXP_BIAS      = 8'd127;
  localparam logic [3:0] MAX_SQUARINGS = 4'd8;   // 1 + 7 extra squarings

  typedef enum logic [1:0] {
    OP_MUL,
    OP_ADD,
    OP_RCP
  } op_e;

  typedef enum logic {
    SA_V,
    SA_ACC
  } sel_a_e;

  typedef enum logic [2:0] {
    SB_QUAD,
    SB_LIN,
    SB_ACC,
    SB_ONE,
    SB_RCP,
    SB_HALF
  } sel_b_e;

  typedef struct packed {
    logic   load;
    logic   start;
    op_e    op;
    sel_a_e sel_a;
    sel_b_e sel_b;
  } cmd_t;

  typedef struct packed {
    logic       done;
    logic [3:0] n_sq;
  } status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fcu_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface fcu_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] x_bits;

  modport source (output valid, output x_bits, input ready);
  modport sink (input valid, input x_bits, output ready);
endinterface

interface fcu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] cosh_bits;

  modport source (output valid, output cosh_bits, input ready);
  modport sink (input valid, input cosh_bits, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/fcu_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fcu_datapath (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [31:0]      x_bits_i,
  input  wire fcu_pkg::cmd_t    cmd_i,
  output fcu_pkg::status_t      status_o,
  output logic [31:0]           res_o
);

  localparam int unsigned DIV_STEPS = 26;
  localparam logic [4:0]  DIV_CNT   = 5'(DIV_STEPS);

  // Round to nearest even, flush underflow, saturate overflow to infinity
  function automatic logic [31:0] round_pack(input logic [23:0] m, input logic g,
                                             input logic s, input logic signed [9:0] e);
    logic              up;
    logic [24:0]       m2;
    logic signed [9:0] e2;
    logic [22:0]       frac;
    up   = g & (s | m[0]);
    m2   = {1'b0, m} + {24'd0, up};
    e2   = e + $signed({9'd0, m2[24]});
    frac = m2[24] ? 23'd0 : m2[22:0];
    if (e2 > 10'sd254) begin
      round_pack = fcu_pkg::FP_INF;
    end else if (e2 < 10'sd1) begin
      round_pack = 32'd0;
    end else begin
      round_pack = {1'b0, e2[7:0], frac};
    end
  endfunction

  logic [31:0] v_q, acc_q, rcp_q;
  logic [3:0]  nsq_q;
  logic        done_q, mul_pend_q, div_pend_q;
  logic [4:0]  cnt_q;
  logic [47:0] prod_q;
  logic signed [9:0] pexp_q;
  logic        mzero_q, minf_q;
  logic [25:0] rem_q, quo_q;
  logic [23:0] div_q;
  logic signed [9:0] rexp_q;

  logic [31:0] opa, opb;
  logic [7:0]  ea, eb;

  always_comb begin
    opa = (cmd_i.sel_a == fcu_pkg::SA_V) ? v_q : acc_q;
    case (cmd_i.sel_b)
      fcu_pkg::SB_QUAD: opb = fcu_pkg::FP_COEF_QUAD;
      fcu_pkg::SB_LIN:  opb = fcu_pkg::FP_COEF_LIN;
      fcu_pkg::SB_ACC:  opb = acc_q;
      fcu_pkg::SB_ONE:  opb = fcu_pkg::FP_ONE;
      fcu_pkg::SB_RCP:  opb = rcp_q;
      fcu_pkg::SB_HALF: opb = fcu_pkg::FP_HALF;
      default:          opb = fcu_pkg::FP_ONE;
    endcase
    ea = opa[30:23];
    eb = opb[30:23];
  end

  // Operand load: clear sign, flush subnormal, fold e >= 0 into [0.5,1)
  logic [31:0] ld_v;
  logic [3:0]  ld_nsq;
  always_comb begin
    ld_v = {1'b0, x_bits_i[30:0]};
    if (x_bits_i[30:23] == 8'd0) begin
      ld_v = 32'd0;
    end
    ld_nsq = 4'd0;
    if (x_bits_i[30:23] >= fcu_pkg::EXP_BIAS) begin
      ld_v = {1'b0, fcu_pkg::SCALE_EXP, x_bits_i[22:0]};
      if (x_bits_i[30:23] >= fcu_pkg::EXP_BIAS + 8'd7) begin
        ld_nsq = fcu_pkg::MAX_SQUARINGS;
      end else begin
        ld_nsq = 4'(x_bits_i[30:23] - fcu_pkg::EXP_BIAS + 8'd1);
      end
    end
  end

  // Adder: both operands are non-negative, so only magnitude addition
  logic [31:0] add_big, add_sml, add_res;
  logic [7:0]  add_d;
  logic [4:0]  add_dc;
  logic [54:0] add_wide;
  logic [27:0] add_x, add_y, add_s;
  logic        add_st;
  always_comb begin
    if (eb > ea) begin
      add_big = opb;
      add_sml = opa;
    end else begin
      add_big = opa;
      add_sml = opb;
    end
    add_d    = add_big[30:23] - add_sml[30:23];
    add_dc   = (add_d > 8'd27) ? 5'd28 : add_d[4:0];
    add_wide = {(add_sml[30:23] != 8'd0), add_sml[22:0], 3'b000, 28'd0} >> add_dc;
    add_st   = |add_wide[27:0];
    add_x    = {1'b0, (add_big[30:23] != 8'd0), add_big[22:0], 3'b000};
    add_y    = {1'b0, add_wide[54:29], add_wide[28] | add_st};
    add_s    = add_x + add_y;
    if (add_big[30:23] == 8'hFF) begin
      add_res = fcu_pkg::FP_INF;
    end else if (add_s[27]) begin
      add_res = round_pack(add_s[27:4], add_s[3], |add_s[2:0],
                           $signed({2'b00, add_big[30:23]}) + 10'sd1);
    end else begin
      add_res = round_pack(add_s[26:3], add_s[2], |add_s[1:0],
                           $signed({2'b00, add_big[30:23]}));
    end
  end

  // Multiplier rounding from the registered product
  logic [31:0] mul_res;
  always_comb begin
    if (mzero_q) begin
      mul_res = 32'd0;
    end else if (minf_q) begin
      mul_res = fcu_pkg::FP_INF;
    end else if (prod_q[47]) begin
      mul_res = round_pack(prod_q[47:24], prod_q[23], |prod_q[22:0], pexp_q + 10'sd1);
    end else begin
      mul_res = round_pack(prod_q[46:23], prod_q[22], |prod_q[21:0], pexp_q);
    end
  end

  // Reciprocal rounding from the quotient and remainder
  logic [31:0] rcp_res;
  always_comb begin
    if (quo_q[25]) begin
      rcp_res = round_pack(quo_q[25:2], quo_q[1], quo_q[0] | (rem_q != 26'd0), rexp_q);
    end else begin
      rcp_res = round_pack(quo_q[24:1], quo_q[0], rem_q != 26'd0, rexp_q - 10'sd1);
    end
  end

  // One restoring division step
  logic [25:0] div_trial;
  logic        div_bit;
  always_comb begin
    div_bit   = rem_q >= {2'b00, div_q};
    div_trial = div_bit ? (rem_q - {2'b00, div_q}) : rem_q;
  end

  logic start_mul, start_add, start_rcp;
  assign start_mul = cmd_i.start && (cmd_i.op == fcu_pkg::OP_MUL);
  assign start_add = cmd_i.start && (cmd_i.op == fcu_pkg::OP_ADD);
  assign start_rcp = cmd_i.start && (cmd_i.op == fcu_pkg::OP_RCP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q     <= 1'b0;
      mul_pend_q <= 1'b0;
      div_pend_q <= 1'b0;
      cnt_q      <= 5'd0;
    end else begin
      done_q <= 1'b0;
      if (start_mul) begin
        mul_pend_q <= 1'b1;
      end else if (mul_pend_q) begin
        mul_pend_q <= 1'b0;
        done_q     <= 1'b1;
      end
      if (start_add) begin
        done_q <= 1'b1;
      end
      if (start_rcp) begin
        if (ea == 8'hFF) begin
          done_q <= 1'b1;
        end else begin
          div_pend_q <= 1'b1;
          cnt_q      <= DIV_CNT;
        end
      end else if (cnt_q != 5'd0) begin
        cnt_q <= cnt_q - 5'd1;
      end else if (div_pend_q) begin
        div_pend_q <= 1'b0;
        done_q     <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      v_q   <= ld_v;
      nsq_q <= ld_nsq;
    end
    if (start_mul) begin
      prod_q  <= {1'b1, opa[22:0]} * {1'b1, opb[22:0]};
      pexp_q  <= $signed({2'b00, ea}) + $signed({2'b00, eb}) - 10'sd127;
      mzero_q <= (ea == 8'd0) || (eb == 8'd0);
      minf_q  <= (ea == 8'hFF) || (eb == 8'hFF);
    end else if (mul_pend_q) begin
      acc_q <= mul_res;
    end
    if (start_add) begin
      acc_q <= add_res;
    end
    if (start_rcp) begin
      if (ea == 8'hFF) begin
        rcp_q <= 32'd0;
      end
      rem_q  <= 26'h0800000;
      quo_q  <= 26'd0;
      div_q  <= {1'b1, opa[22:0]};
      rexp_q <= 10'sd254 - $signed({2'b00, ea});
    end else if (cnt_q != 5'd0) begin
      rem_q <= {div_trial[24:0], 1'b0};
      quo_q <= {quo_q[24:0], div_bit};
    end else if (div_pend_q) begin
      rcp_q <= rcp_res;
    end
  end

  assign status_o.done = done_q;
  assign status_o.n_sq = nsq_q;
  assign res_o         = acc_q;

endmodule

`default_nettype wire

// ----- hw/rtl/fcu_controller.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fcu_controller (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             out_free_i,
  output logic                  res_load_o,
  input  wire fcu_pkg::status_t status_i,
  output fcu_pkg::cmd_t         cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  localparam logic [2:0] P_LIN  = 3'd0;  // v * c1
  localparam logic [2:0] P_ADD0 = 3'd1;  // + c0
  localparam logic [2:0] P_MULV = 3'd2;  // v * t
  localparam logic [2:0] P_ADD1 = 3'd3;  // + 1
  localparam logic [2:0] P_SQ   = 3'd4;  // y * y
  localparam logic [2:0] P_RCP  = 3'd5;  // 1 / y
  localparam logic [2:0] P_SUM  = 3'd6;  // y + 1/y
  localparam logic [2:0] P_HALF = 3'd7;  // * 0.5

  logic [1:0] state_q, state_d;
  logic [2:0] pc_q, pc_d;
  logic [3:0] sq_q, sq_d;

  always_comb begin
    cmd_o       = '0;
    cmd_o.op    = fcu_pkg::OP_MUL;
    cmd_o.sel_a = fcu_pkg::SA_ACC;
    cmd_o.sel_b = fcu_pkg::SB_ACC;
    in_ready_o  = (state_q == S_IDLE);
    res_load_o  = (state_q == S_OUT) && out_free_i;
    cmd_o.load  = (state_q == S_IDLE) && in_valid_i;
    cmd_o.start = (state_q == S_ISSUE);
    case (pc_q)
      P_LIN: begin
        cmd_o.sel_a = fcu_pkg::SA_V;
        cmd_o.sel_b = fcu_pkg::SB_QUAD;
      end
      P_ADD0: begin
        cmd_o.op    = fcu_pkg::OP_ADD;
        cmd_o.sel_b = fcu_pkg::SB_LIN;
      end
      P_MULV: begin
        cmd_o.sel_a = fcu_pkg::SA_V;
      end
      P_ADD1: begin
        cmd_o.op    = fcu_pkg::OP_ADD;
        cmd_o.sel_b = fcu_pkg::SB_ONE;
      end
      P_SQ: begin
        cmd_o.op = fcu_pkg::OP_MUL;
      end
      P_RCP: begin
        cmd_o.op = fcu_pkg::OP_RCP;
      end
      P_SUM: begin
        cmd_o.op    = fcu_pkg::OP_ADD;
        cmd_o.sel_b = fcu_pkg::SB_RCP;
      end
      P_HALF: begin
        cmd_o.sel_b = fcu_pkg::SB_HALF;
      end
      default: begin
        cmd_o.op = fcu_pkg::OP_MUL;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    sq_d    = sq_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_ISSUE;
          pc_d    = P_LIN;
        end
      end
      S_ISSUE: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (status_i.done) begin
          state_d = S_ISSUE;
          case (pc_q)
            P_ADD1: begin
              // skip the squaring loop for operands below one
              if (status_i.n_sq == 4'd0) begin
                pc_d = P_RCP;
              end else begin
                pc_d = P_SQ;
                sq_d = status_i.n_sq;
              end
            end
            P_SQ: begin
              if (sq_q == 4'd1) begin
                pc_d = P_RCP;
              end else begin
                sq_d = sq_q - 4'd1;
              end
            end
            P_HALF: begin
              state_d = S_OUT;
            end
            default: begin
              pc_d = pc_q + 3'd1;
            end
          endcase
        end
      end
      S_OUT: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= P_LIN;
      sq_q    <= 4'd0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      sq_q    <= sq_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/float_cosh_unit.sv -----
// float_cosh_unit: approximate hyperbolic cosine of one single-precision float.
// Input channel in_i carries x_bits; an item is taken when valid and ready are
// both high. Output channel out_o carries cosh_bits under the same handshake.
// The operand's sign is dropped; values of magnitude one or more are folded to
// [0.5,1), run through a quadratic series for e^v and squared 1..8 times. The
// reciprocal is added and the sum halved. Every step rounds to nearest even,
// flushes subnormals and saturates overflow to +infinity.
// One item is in work at a time. Every multiply runs on the shared multiplier,
// and the reciprocal comes from the 26-step restoring divider. The squarings
// run only for operands of magnitude one or more. The next item is taken once
// the previous result has moved into the output register.
// A finished result sits in an output register; the block takes the next item
// while that result waits, and holds the following one back only until the
// register frees. While out_o.valid is high and out_o.ready is low, out_o.valid
// and cosh_bits hold. Reset empties the output register and returns the
// controller to idle.
`timescale 1ns / 1ps
`default_nettype none

module float_cosh_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fcu_in_if.sink    in_i,
  fcu_out_if.source out_o
);

  fcu_pkg::cmd_t    cmd;
  fcu_pkg::status_t status;
  logic             res_load;
  logic             out_free;
  logic [31:0]      res;

  logic        out_valid_q;
  logic [31:0] out_bits_q;

  // output register is free when empty or being drained this cycle
  assign out_free = !out_valid_q || out_o.ready;

  fcu_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_free_i (out_free),
    .res_load_o (res_load),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fcu_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .x_bits_i (in_i.x_bits),
    .cmd_i    (cmd),
    .status_o (status),
    .res_o    (res)
  );

  // hold the result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_bits_q <= res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.cosh_bits = out_bits_q;

endmodule

`default_nettype wire

// ----- hw/rtl/fcu_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fcu_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [31:0] cosh_bits_i
);

  // a stalled item holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(cosh_bits_i))
    else $error("stalled result changed");

  // one item at a time: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second item taken while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> ##2 !$rose(out_valid_i))
    else $error("result too early");

  // cosh is never below one and never negative
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !cosh_bits_i[31] && (cosh_bits_i[30:23] >= 8'd127))
    else $error("result below one");

endmodule

bind float_cosh_unit fcu_checker u_fcu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .cosh_bits_i (out_o.cosh_bits)
);

`default_nettype wire
